// File: hdl/mmtc_pkg.sv
// ----------------------------------------------------------------------------
// mmtc_pkg
// Shared types, command codes and the pitch table for the tone controller.
// ----------------------------------------------------------------------------
package mmtc_pkg;

    localparam int unsigned TABLE_ENTRIES = 381;
    localparam logic [20:0] DIV_NUMERATOR = 21'd1331000;

    typedef enum logic [3:0] {
        CMD_STOP     = 4'd0,
        CMD_START    = 4'd1,
        CMD_CTRL     = 4'd2,
        CMD_BEND     = 4'd3,
        CMD_STOP_ALL = 4'd4,
        CMD_ENABLE   = 4'd5,
        CMD_SPARE    = 4'd6,
        CMD_FLAG     = 4'd7,
        CMD_QUERY    = 4'd8
    } t_cmd;

    localparam logic [7:0] CC_ALL_OFF  = 8'h7b;
    localparam logic [7:0] CC_CLAIM    = 8'h4b;
    localparam logic [7:0] CC_REPLAY   = 8'h4e;
    localparam logic [7:0] CC_VOLUME   = 8'h07;
    localparam logic [7:0] ST_BEND     = 8'he0;
    localparam logic [7:0] ST_CTRL     = 8'hb0;
    localparam logic [7:0] NOTE_LOW    = 8'h18;
    localparam logic [7:0] NOTE_HIGH   = 8'h77;
    localparam logic [7:0] READ_ONLY   = 8'hff;
    localparam logic [7:0] NO_OWNER    = 8'hff;
    localparam logic [15:0] BEND_CTR   = 16'h2000;
    localparam logic [15:0] IDX_MAX    = 16'h01dc;
    localparam logic [15:0] BEND_DIV   = 16'h00ab;

    // datapath -> controller
    typedef struct packed {
        logic play_req;   // item needs a division
        logic div_done;
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic exec;       // capture accepted item
        logic div_start;
        logic div_step;
        logic finish;     // commit divisor, load output
    } t_cmd_bus;

    typedef logic [13:0] t_pitch;

    function automatic t_pitch pitch_rom(input logic [8:0] idx);
        t_pitch v;
        case (idx)
            9'd0: v=14'd37; 9'd1: v=14'd37; 9'd2: v=14'd38; 9'd3: v=14'd38;
            9'd4: v=14'd39; 9'd5: v=14'd39; 9'd6: v=14'd40; 9'd7: v=14'd41;
            9'd8: v=14'd41; 9'd9: v=14'd42; 9'd10: v=14'd42; 9'd11: v=14'd43;
            9'd12: v=14'd44; 9'd13: v=14'd44; 9'd14: v=14'd45; 9'd15: v=14'd46;
            9'd16: v=14'd46; 9'd17: v=14'd47; 9'd18: v=14'd48; 9'd19: v=14'd48;
            9'd20: v=14'd49; 9'd21: v=14'd50; 9'd22: v=14'd50; 9'd23: v=14'd51;
            9'd24: v=14'd52; 9'd25: v=14'd53; 9'd26: v=14'd53; 9'd27: v=14'd54;
            9'd28: v=14'd55; 9'd29: v=14'd56; 9'd30: v=14'd57; 9'd31: v=14'd57;
            9'd32: v=14'd58; 9'd33: v=14'd59; 9'd34: v=14'd60; 9'd35: v=14'd61;
            9'd36: v=14'd62; 9'd37: v=14'd63; 9'd38: v=14'd63; 9'd39: v=14'd64;
            9'd40: v=14'd65; 9'd41: v=14'd66; 9'd42: v=14'd67; 9'd43: v=14'd68;
            9'd44: v=14'd69; 9'd45: v=14'd70; 9'd46: v=14'd71; 9'd47: v=14'd72;
            9'd48: v=14'd73; 9'd49: v=14'd74; 9'd50: v=14'd76; 9'd51: v=14'd77;
            9'd52: v=14'd78; 9'd53: v=14'd79; 9'd54: v=14'd80; 9'd55: v=14'd81;
            9'd56: v=14'd82; 9'd57: v=14'd84; 9'd58: v=14'd85; 9'd59: v=14'd86;
            9'd60: v=14'd87; 9'd61: v=14'd89; 9'd62: v=14'd90; 9'd63: v=14'd91;
            9'd64: v=14'd92; 9'd65: v=14'd94; 9'd66: v=14'd95; 9'd67: v=14'd97;
            9'd68: v=14'd98; 9'd69: v=14'd99; 9'd70: v=14'd101; 9'd71: v=14'd102;
            9'd72: v=14'd104; 9'd73: v=14'd105; 9'd74: v=14'd107; 9'd75: v=14'd108;
            9'd76: v=14'd110; 9'd77: v=14'd112; 9'd78: v=14'd113; 9'd79: v=14'd115;
            9'd80: v=14'd116; 9'd81: v=14'd118; 9'd82: v=14'd120; 9'd83: v=14'd122;
            9'd84: v=14'd123; 9'd85: v=14'd125; 9'd86: v=14'd127; 9'd87: v=14'd129;
            9'd88: v=14'd131; 9'd89: v=14'd133; 9'd90: v=14'd135; 9'd91: v=14'd137;
            9'd92: v=14'd139; 9'd93: v=14'd141; 9'd94: v=14'd143; 9'd95: v=14'd145;
            9'd96: v=14'd147; 9'd97: v=14'd149; 9'd98: v=14'd151; 9'd99: v=14'd153;
            9'd100: v=14'd156; 9'd101: v=14'd158; 9'd102: v=14'd160; 9'd103: v=14'd162;
            9'd104: v=14'd165; 9'd105: v=14'd167; 9'd106: v=14'd170; 9'd107: v=14'd172;
            9'd108: v=14'd175; 9'd109: v=14'd177; 9'd110: v=14'd180; 9'd111: v=14'd182;
            9'd112: v=14'd185; 9'd113: v=14'd188; 9'd114: v=14'd190; 9'd115: v=14'd193;
            9'd116: v=14'd196; 9'd117: v=14'd199; 9'd118: v=14'd202; 9'd119: v=14'd205;
            9'd120: v=14'd208; 9'd121: v=14'd211; 9'd122: v=14'd214; 9'd123: v=14'd217;
            9'd124: v=14'd220; 9'd125: v=14'd223; 9'd126: v=14'd226; 9'd127: v=14'd230;
            9'd128: v=14'd233; 9'd129: v=14'd236; 9'd130: v=14'd240; 9'd131: v=14'd243;
            9'd132: v=14'd247; 9'd133: v=14'd250; 9'd134: v=14'd254; 9'd135: v=14'd258;
            9'd136: v=14'd262; 9'd137: v=14'd265; 9'd138: v=14'd269; 9'd139: v=14'd273;
            9'd140: v=14'd277; 9'd141: v=14'd281; 9'd142: v=14'd285; 9'd143: v=14'd289;
            9'd144: v=14'd294; 9'd145: v=14'd298; 9'd146: v=14'd302; 9'd147: v=14'd307;
            9'd148: v=14'd311; 9'd149: v=14'd316; 9'd150: v=14'd320; 9'd151: v=14'd325;
            9'd152: v=14'd330; 9'd153: v=14'd334; 9'd154: v=14'd339; 9'd155: v=14'd344;
            9'd156: v=14'd349; 9'd157: v=14'd354; 9'd158: v=14'd359; 9'd159: v=14'd365;
            9'd160: v=14'd370; 9'd161: v=14'd375; 9'd162: v=14'd381; 9'd163: v=14'd386;
            9'd164: v=14'd392; 9'd165: v=14'd398; 9'd166: v=14'd403; 9'd167: v=14'd409;
            9'd168: v=14'd415; 9'd169: v=14'd421; 9'd170: v=14'd427; 9'd171: v=14'd434;
            9'd172: v=14'd440; 9'd173: v=14'd446; 9'd174: v=14'd453; 9'd175: v=14'd459;
            9'd176: v=14'd466; 9'd177: v=14'd473; 9'd178: v=14'd480; 9'd179: v=14'd487;
            9'd180: v=14'd494; 9'd181: v=14'd501; 9'd182: v=14'd508; 9'd183: v=14'd516;
            9'd184: v=14'd523; 9'd185: v=14'd531; 9'd186: v=14'd539; 9'd187: v=14'd546;
            9'd188: v=14'd554; 9'd189: v=14'd562; 9'd190: v=14'd571; 9'd191: v=14'd579;
            9'd192: v=14'd587; 9'd193: v=14'd596; 9'd194: v=14'd604; 9'd195: v=14'd613;
            9'd196: v=14'd622; 9'd197: v=14'd631; 9'd198: v=14'd640; 9'd199: v=14'd650;
            9'd200: v=14'd659; 9'd201: v=14'd669; 9'd202: v=14'd679; 9'd203: v=14'd688;
            9'd204: v=14'd698; 9'd205: v=14'd709; 9'd206: v=14'd719; 9'd207: v=14'd729;
            9'd208: v=14'd740; 9'd209: v=14'd751; 9'd210: v=14'd762; 9'd211: v=14'd773;
            9'd212: v=14'd784; 9'd213: v=14'd795; 9'd214: v=14'd807; 9'd215: v=14'd819;
            9'd216: v=14'd831; 9'd217: v=14'd843; 9'd218: v=14'd855; 9'd219: v=14'd867;
            9'd220: v=14'd880; 9'd221: v=14'd893; 9'd222: v=14'd906; 9'd223: v=14'd919;
            9'd224: v=14'd932; 9'd225: v=14'd946; 9'd226: v=14'd960; 9'd227: v=14'd974;
            9'd228: v=14'd988; 9'd229: v=14'd1002; 9'd230: v=14'd1017; 9'd231: v=14'd1031;
            9'd232: v=14'd1046; 9'd233: v=14'd1062; 9'd234: v=14'd1077; 9'd235: v=14'd1093;
            9'd236: v=14'd1109; 9'd237: v=14'd1125; 9'd238: v=14'd1141; 9'd239: v=14'd1158;
            9'd240: v=14'd1175; 9'd241: v=14'd1192; 9'd242: v=14'd1209; 9'd243: v=14'd1227;
            9'd244: v=14'd1244; 9'd245: v=14'd1263; 9'd246: v=14'd1281; 9'd247: v=14'd1300;
            9'd248: v=14'd1318; 9'd249: v=14'd1338; 9'd250: v=14'd1357; 9'd251: v=14'd1377;
            9'd252: v=14'd1397; 9'd253: v=14'd1417; 9'd254: v=14'd1438; 9'd255: v=14'd1459;
            9'd256: v=14'd1480; 9'd257: v=14'd1501; 9'd258: v=14'd1523; 9'd259: v=14'd1545;
            9'd260: v=14'd1568; 9'd261: v=14'd1591; 9'd262: v=14'd1614; 9'd263: v=14'd1637;
            9'd264: v=14'd1661; 9'd265: v=14'd1685; 9'd266: v=14'd1710; 9'd267: v=14'd1735;
            9'd268: v=14'd1760; 9'd269: v=14'd1786; 9'd270: v=14'd1812; 9'd271: v=14'd1838;
            9'd272: v=14'd1865; 9'd273: v=14'd1892; 9'd274: v=14'd1919; 9'd275: v=14'd1947;
            9'd276: v=14'd1975; 9'd277: v=14'd2004; 9'd278: v=14'd2033; 9'd279: v=14'd2063;
            9'd280: v=14'd2093; 9'd281: v=14'd2123; 9'd282: v=14'd2154; 9'd283: v=14'd2186;
            9'd284: v=14'd2217; 9'd285: v=14'd2250; 9'd286: v=14'd2282; 9'd287: v=14'd2316;
            9'd288: v=14'd2349; 9'd289: v=14'd2383; 9'd290: v=14'd2418; 9'd291: v=14'd2453;
            9'd292: v=14'd2489; 9'd293: v=14'd2525; 9'd294: v=14'd2562; 9'd295: v=14'd2599;
            9'd296: v=14'd2637; 9'd297: v=14'd2675; 9'd298: v=14'd2714; 9'd299: v=14'd2754;
            9'd300: v=14'd2794; 9'd301: v=14'd2834; 9'd302: v=14'd2876; 9'd303: v=14'd2917;
            9'd304: v=14'd2960; 9'd305: v=14'd3003; 9'd306: v=14'd3047; 9'd307: v=14'd3091;
            9'd308: v=14'd3136; 9'd309: v=14'd3182; 9'd310: v=14'd3228; 9'd311: v=14'd3275;
            9'd312: v=14'd3322; 9'd313: v=14'd3371; 9'd314: v=14'd3420; 9'd315: v=14'd3469;
            9'd316: v=14'd3520; 9'd317: v=14'd3571; 9'd318: v=14'd3623; 9'd319: v=14'd3676;
            9'd320: v=14'd3729; 9'd321: v=14'd3783; 9'd322: v=14'd3839; 9'd323: v=14'd3894;
            9'd324: v=14'd3951; 9'd325: v=14'd4008; 9'd326: v=14'd4067; 9'd327: v=14'd4126;
            9'd328: v=14'd4186; 9'd329: v=14'd4247; 9'd330: v=14'd4309; 9'd331: v=14'd4371;
            9'd332: v=14'd4435; 9'd333: v=14'd4499; 9'd334: v=14'd4565; 9'd335: v=14'd4631;
            9'd336: v=14'd4699; 9'd337: v=14'd4767; 9'd338: v=14'd4836; 9'd339: v=14'd4907;
            9'd340: v=14'd4978; 9'd341: v=14'd5050; 9'd342: v=14'd5124; 9'd343: v=14'd5198;
            9'd344: v=14'd5274; 9'd345: v=14'd5351; 9'd346: v=14'd5429; 9'd347: v=14'd5507;
            9'd348: v=14'd5588; 9'd349: v=14'd5669; 9'd350: v=14'd5751; 9'd351: v=14'd5835;
            9'd352: v=14'd5920; 9'd353: v=14'd6006; 9'd354: v=14'd6093; 9'd355: v=14'd6182;
            9'd356: v=14'd6272; 9'd357: v=14'd6363; 9'd358: v=14'd6456; 9'd359: v=14'd6550;
            9'd360: v=14'd6645; 9'd361: v=14'd6741; 9'd362: v=14'd6840; 9'd363: v=14'd6939;
            9'd364: v=14'd7040; 9'd365: v=14'd7142; 9'd366: v=14'd7246; 9'd367: v=14'd7352;
            9'd368: v=14'd7459; 9'd369: v=14'd7567; 9'd370: v=14'd7677; 9'd371: v=14'd7789;
            9'd372: v=14'd7902; 9'd373: v=14'd8016; 9'd374: v=14'd8134; 9'd375: v=14'd8252;
            9'd376: v=14'd8372; 9'd377: v=14'd8494; 9'd378: v=14'd8618; 9'd379: v=14'd8742;
            9'd380: v=14'd8870;
            default: v = 14'd1;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/mmtc_stream_if.sv
// ----------------------------------------------------------------------------
// mmtc_stream_if
// Valid/ready channel carrying one payload of generic type.
// ----------------------------------------------------------------------------
interface mmtc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/mmtc_ctrl.sv
// ----------------------------------------------------------------------------
// mmtc_ctrl
// Sequencer: accept, decode, divide (21 steps) for items that program a tone, deliver.
// ----------------------------------------------------------------------------
module mmtc_ctrl
    import mmtc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_status  i_status,
    output t_cmd_bus o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.play_req) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_exec_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DIV || r_state == S_OUT))
        else $error("exec did not advance");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result dropped");
`endif

endmodule

// File: hdl/mmtc_datapath.sv
// ----------------------------------------------------------------------------
// mmtc_datapath
// Command decode, note/bend state, restoring divider and result register.
// ----------------------------------------------------------------------------
module mmtc_datapath
    import mmtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_bus    i_cmd,
    output t_status     o_status,
    input  logic [3:0]  i_command,
    input  logic [7:0]  i_channel,
    input  logic [7:0]  i_status,
    input  logic [7:0]  i_data_hi,
    input  logic [7:0]  i_data_lo,
    output logic [15:0] o_reply,
    output logic        o_gate,
    output logic [15:0] o_divisor,
    output logic        o_divisor_written
);

    // captured item
    logic [3:0]  r_cmd;
    logic [7:0]  r_ch, r_st, r_hi, r_lo;

    // architectural state
    logic [7:0]  r_note, r_owner, r_bend_steps, r_enable, r_spare;
    logic        r_bend_up, r_volume, r_flag, r_gate;
    logic [15:0] r_last_bend, r_div;

    // pending play
    logic        r_play;
    logic [13:0] r_den;
    logic [20:0] r_quo;
    logic [14:0] r_rem;
    logic [4:0]  r_cnt;

    logic [15:0] r_reply_o, r_div_o;
    logic        r_gate_o, r_wr_o;

    // next state from decode
    logic [7:0]  n_note, n_owner, n_bend_steps, n_enable, n_spare;
    logic        n_bend_up, n_volume, n_flag, n_gate;
    logic [15:0] n_last_bend, n_reply;
    logic        n_play;
    logic [8:0]  n_idx;

    // bend magnitude: away / 0xab, away <= 0x5f80
    logic [15:0] bend_v, bend_away;
    logic [7:0]  bend_q;

    assign bend_v    = {1'b0, r_lo, 7'd0};
    assign bend_away = (bend_v > BEND_CTR) ? (bend_v - BEND_CTR) : (BEND_CTR - bend_v);
    // reciprocal: floor(x/171) = (x*24529)>>22 exact for x < 27060
    logic [29:0] bend_prod;
    assign bend_prod = bend_away[14:0] * 15'd24529;
    assign bend_q    = bend_prod[29:22];

    always_comb begin
        logic [15:0] idx;
        logic [7:0]  pn;
        logic        do_play;
        n_note = r_note; n_owner = r_owner; n_bend_steps = r_bend_steps;
        n_enable = r_enable; n_spare = r_spare; n_bend_up = r_bend_up;
        n_volume = r_volume; n_flag = r_flag; n_gate = r_gate;
        n_last_bend = r_last_bend; n_reply = '0;
        do_play = 1'b0; pn = '0;
        n_play = 1'b0; n_idx = '0; idx = '0;
        case (r_cmd)
            CMD_STOP: begin
                if (r_note == r_hi && r_note != 8'd0) begin
                    n_gate = 1'b0; n_note = '0;
                end
            end
            CMD_START: begin
                if (r_owner == r_ch && r_hi != 8'd0) begin
                    if (r_note != 8'd0) begin
                        n_gate = 1'b0; n_note = '0;
                    end
                    do_play = 1'b1; pn = r_hi;
                end
            end
            CMD_CTRL: begin
                if (r_hi == CC_ALL_OFF) begin
                    if (r_note != 8'd0) begin n_gate = 1'b0; n_note = '0; end
                end else if (r_hi == CC_CLAIM) begin
                    if (r_lo != 8'd0) begin
                        if (r_owner != r_ch) begin
                            if (r_note != 8'd0) begin n_gate = 1'b0; n_note = '0; end
                            n_owner = r_ch;
                        end
                    end else if (r_owner == r_ch) begin
                        if (r_note != 8'd0) begin n_gate = 1'b0; n_note = '0; end
                        n_owner = NO_OWNER;
                    end
                end else if (r_hi == CC_REPLAY) begin
                    if (r_lo != READ_ONLY && r_owner == r_ch) begin
                        if (r_note != 8'd0) begin n_gate = 1'b0; n_note = '0; end
                        do_play = 1'b1; pn = r_lo;
                    end
                end else if (r_hi == CC_VOLUME) begin
                    n_volume = 1'b1;
                    if (r_lo == 8'd0) begin
                        if (r_note != 8'd0) begin n_gate = 1'b0; n_note = '0; end
                        n_volume = 1'b0;
                    end
                end
            end
            CMD_BEND: begin
                n_last_bend = {1'b0, r_lo, r_hi[6:0]} | {8'd0, r_hi[7], 7'd0};
                if (r_owner == r_ch) begin
                    n_bend_up = bend_v > BEND_CTR;
                    n_bend_steps = (bend_v == BEND_CTR) ? 8'd0 : bend_q;
                    if (r_note != 8'd0) begin
                        do_play = 1'b1; pn = r_note;
                    end
                end
            end
            CMD_STOP_ALL: begin
                if (r_note != 8'd0) begin n_gate = 1'b0; n_note = '0; end
            end
            CMD_ENABLE: begin
                n_reply = {15'd0, r_enable != 8'd0};
                if (r_lo != READ_ONLY) begin
                    n_enable = r_lo;
                    if (r_lo == 8'd0 && r_note != 8'd0) begin
                        n_gate = 1'b0; n_note = '0;
                    end
                end
            end
            CMD_SPARE: begin
                n_reply = {8'd0, r_spare};
                if (r_lo != READ_ONLY) n_spare = r_lo;
            end
            CMD_FLAG: begin
                n_reply = {15'd0, r_flag};
                if (r_lo != READ_ONLY) begin
                    n_flag = r_lo != 8'd0;
                    if (r_lo == 8'd0 && r_note != 8'd0) begin
                        n_gate = 1'b0; n_note = '0;
                    end
                end
            end
            CMD_QUERY: begin
                if (r_st == ST_BEND) n_reply = r_last_bend;
                else if (r_st == ST_CTRL && r_hi == CC_CLAIM && r_lo == READ_ONLY)
                    n_reply = {15'd0, r_ch == r_owner};
                else n_reply = 16'hffff;
            end
            default: ;
        endcase

        // note-on, using the bend already in force for this item
        if (do_play && pn >= NOTE_LOW && pn <= NOTE_HIGH) begin
            n_note = pn;
            idx = {6'd0, pn - NOTE_LOW, 2'b00};
            n_play = 1'b1;
            if (n_bend_steps != 8'd0) begin
                idx = n_bend_up ? idx + {8'd0, n_bend_steps} : idx - {8'd0, n_bend_steps};
                if (idx < 16'(NOTE_LOW) || idx > IDX_MAX || idx > 16'(TABLE_ENTRIES - 1))
                    n_play = 1'b0;
            end
            if (n_enable == 8'd0 || !n_volume || !n_flag) n_play = 1'b0;
            n_idx = idx[8:0];
        end
    end

    // decode runs combinationally on the captured item during EXEC
    assign o_status.play_req = n_play;
    assign o_status.div_done = (r_cnt == 5'd0);

    // items that program no divisor commit everything at finish
    logic fin_commit;
    assign fin_commit = i_cmd.finish && !r_play;

    logic [14:0] div_trial;
    logic [14:0] div_shift;
    assign div_shift = {r_rem[13:0], r_quo[20]};
    assign div_trial = div_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cmd <= i_command; r_ch <= i_channel; r_st <= i_status;
            r_hi <= i_data_hi;  r_lo <= i_data_lo;
        end
        if (i_cmd.div_start) begin
            r_quo <= DIV_NUMERATOR;
            r_rem <= '0;
            r_cnt <= 5'd21;
        end else if (i_cmd.div_step && r_cnt != 5'd0) begin
            if (!div_trial[14]) begin
                r_rem <= div_trial;
                r_quo <= {r_quo[19:0], 1'b1};
            end else begin
                r_rem <= div_shift;
                r_quo <= {r_quo[19:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note <= '0; r_owner <= NO_OWNER; r_bend_steps <= '0; r_bend_up <= 1'b0;
            r_last_bend <= BEND_CTR; r_enable <= 8'd1; r_volume <= 1'b1;
            r_flag <= 1'b1; r_spare <= '0; r_gate <= 1'b0; r_div <= '0;
            r_play <= 1'b0; r_den <= 14'd1;
            r_reply_o <= '0; r_gate_o <= 1'b0; r_div_o <= '0; r_wr_o <= 1'b0;
        end else begin
            if (i_cmd.div_start) begin
                // decode commits here; the divisor and the raised gate wait for the quotient
                r_note <= n_note; r_owner <= n_owner; r_bend_steps <= n_bend_steps;
                r_bend_up <= n_bend_up; r_last_bend <= n_last_bend;
                r_enable <= n_enable; r_volume <= n_volume; r_flag <= n_flag;
                r_spare <= n_spare; r_gate <= n_gate; r_reply_o <= n_reply;
                r_play <= 1'b1;
                r_den  <= pitch_rom(n_idx);
            end
            if (i_cmd.exec) begin
                r_play <= 1'b0;
            end
            if (fin_commit) begin
                r_note <= n_note; r_owner <= n_owner; r_bend_steps <= n_bend_steps;
                r_bend_up <= n_bend_up; r_last_bend <= n_last_bend;
                r_enable <= n_enable; r_volume <= n_volume; r_flag <= n_flag;
                r_spare <= n_spare; r_gate <= n_gate;
                r_reply_o <= n_reply; r_gate_o <= n_gate; r_div_o <= r_div;
                r_wr_o <= 1'b0;
            end
            if (i_cmd.finish && r_play) begin
                r_div <= r_quo[15:0]; r_gate <= 1'b1;
                r_gate_o <= 1'b1; r_div_o <= r_quo[15:0]; r_wr_o <= 1'b1;
            end
        end
    end

    assign o_reply = r_reply_o;
    assign o_gate = r_gate_o;
    assign o_divisor = r_div_o;
    assign o_divisor_written = r_wr_o;

`ifndef SYNTHESIS
    a_wr_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_o |-> (r_gate_o && r_div_o == r_div)) else $error("write without gate");
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_den != 14'd0)) else $error("zero divisor");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_cnt == 5'd21)) else $error("divider not loaded");
`endif

endmodule

// File: hdl/monophonic_midi_tone_controller.sv
// ----------------------------------------------------------------------------
// monophonic_midi_tone_controller
// One-voice tone controller for MIDI-like commands.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one command and yields exactly one
// transfer on the output channel. The command is decoded in the EXEC state,
// entered in the cycle after accept. Items that need no division raise result
// valid in the cycle after EXEC; an item that programs the tone (note-on,
// replay, bend of a sounding note) passes EXEC, then the 21-step restoring
// divider that forms 1331000 / table entry one quotient bit per cycle and then
// sees the count run out, then FIN loads the result. The block takes one
// item at a time; input ready returns the cycle after the result transfer.
// ----------------------------------------------------------------------------
module monophonic_midi_tone_controller
    import mmtc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mmtc_stream_if.sink   s_in,
    mmtc_stream_if.source m_out
);

    t_status  status;
    t_cmd_bus cmd;

    mmtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // decode is combinational on the captured item during the EXEC state
    mmtc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_command         (s_in.data.command),
        .i_channel         (s_in.data.channel),
        .i_status          (s_in.data.status),
        .i_data_hi         (s_in.data.data_hi),
        .i_data_lo         (s_in.data.data_lo),
        .o_reply           (m_out.data.reply),
        .o_gate            (m_out.data.gate),
        .o_divisor         (m_out.data.divisor),
        .o_divisor_written (m_out.data.divisor_written)
    );

endmodule
